/* rtl/core/tmr_pkg.sv */
// Shared types and constants for the timer/counter block.
package tmr_pkg;

    localparam int COUNT_WIDTH    = 8;
    localparam int PRESCALE_WIDTH = 10;
    localparam int BYTE_WIDTH     = 8;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [2:0] REG_CONTROL = 3'd0;
    localparam logic [2:0] REG_COUNTER = 3'd1;
    localparam logic [2:0] REG_COMPARE = 3'd2;
    localparam logic [2:0] REG_MASK    = 3'd3;
    localparam logic [2:0] REG_FLAGS   = 3'd4;

    localparam logic [2:0] CS_STOP    = 3'd0;
    localparam logic [2:0] CS_DIV1    = 3'd1;
    localparam logic [2:0] CS_DIV8    = 3'd2;
    localparam logic [2:0] CS_DIV64   = 3'd3;
    localparam logic [2:0] CS_DIV256  = 3'd4;
    localparam logic [2:0] CS_DIV1024 = 3'd5;
    localparam logic [2:0] CS_FALL    = 3'd6;
    localparam logic [2:0] CS_RISE    = 3'd7;

    localparam int FLAG_OVF = 0;
    localparam int FLAG_CMP = 1;

    typedef struct packed {
        logic [1:0] operation;
        logic [2:0] reg_select;
        logic [7:0] write_data;
        logic       ext_pin;
    } tmr_in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       overflow_flag;
        logic       compare_flag;
        logic       irq;
    } tmr_out_t;

    typedef struct packed {
        logic       tick;
        logic [2:0] clk_sel;
        logic       pin;
    } tick_ctrl_t;

    typedef struct packed {
        logic [1:0] flags;
        logic [1:0] enables;
    } tmr_status_t;

endpackage

/* rtl/core/tmr_prescaler.sv */
// Free-running prescaler, pin edge detector and count event select.
module tmr_prescaler (
    input  logic                clk,
    input  logic                rst_n,
    input  tmr_pkg::tick_ctrl_t ctrl,
    output logic                count_event
);
    import tmr_pkg::*;

    logic [PRESCALE_WIDTH-1:0] prescale_reg;
    logic [PRESCALE_WIDTH-1:0] prescale_next;
    logic                      pin_reg;

    assign prescale_next = prescale_reg + PRESCALE_WIDTH'(1);

    always_comb
    begin
        case (ctrl.clk_sel)
            CS_DIV1:    count_event = 1'b1;
            CS_DIV8:    count_event = (prescale_next[2:0] == 3'd0);
            CS_DIV64:   count_event = (prescale_next[5:0] == 6'd0);
            CS_DIV256:  count_event = (prescale_next[7:0] == 8'd0);
            CS_DIV1024: count_event = (prescale_next == '0);
            CS_FALL:    count_event = pin_reg && !ctrl.pin;
            CS_RISE:    count_event = !pin_reg && ctrl.pin;
            default:    count_event = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_reg <= '0;
            pin_reg      <= 1'b0;
        end
        else if (ctrl.tick)
        begin
            prescale_reg <= prescale_next;
            pin_reg      <= ctrl.pin;
        end
    end

endmodule

/* rtl/core/tmr_core.sv */
// Counter, compare, control, mask and flag registers with read and write decode.
module tmr_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  tmr_pkg::tmr_in_t     item,
    input  logic                 count_event,
    output tmr_pkg::tick_ctrl_t  tick_ctrl,
    output tmr_pkg::tmr_out_t    result,
    output tmr_pkg::tmr_status_t status
);
    import tmr_pkg::*;

    logic [COUNT_WIDTH-1:0] count_reg,   count_next;
    logic [COUNT_WIDTH-1:0] compare_reg, compare_next;
    logic [3:0]             ctrl_reg,    ctrl_next;
    logic [1:0]             mask_reg,    mask_next;
    logic [1:0]             flags_reg,   flags_next;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic                   is_tick;
    logic                   is_read;
    logic                   is_write;
    logic [7:0]             read_byte;

    assign is_tick  = (item.operation == OP_TICK);
    assign is_read  = (item.operation == OP_READ);
    assign is_write = (item.operation == OP_WRITE);

    assign tick_ctrl.tick    = fire && is_tick;
    assign tick_ctrl.clk_sel = ctrl_reg[2:0];
    assign tick_ctrl.pin     = item.ext_pin;

    always_comb
    begin
        if (ctrl_reg[3] && (count_reg == compare_reg))
            count_inc = '0;
        else
            count_inc = count_reg + COUNT_WIDTH'(1);
    end

    always_comb
    begin
        count_next   = count_reg;
        compare_next = compare_reg;
        ctrl_next    = ctrl_reg;
        mask_next    = mask_reg;
        flags_next   = flags_reg;
        if (is_tick && count_event)
        begin
            count_next = count_inc;
            if ((count_reg == {COUNT_WIDTH{1'b1}}) && (count_inc == '0))
                flags_next[FLAG_OVF] = 1'b1;
            if (count_inc == compare_reg)
                flags_next[FLAG_CMP] = 1'b1;
        end
        else if (is_write)
        begin
            case (item.reg_select)
                REG_CONTROL: ctrl_next    = item.write_data[3:0];
                REG_COUNTER: count_next   = COUNT_WIDTH'(item.write_data);
                REG_COMPARE: compare_next = COUNT_WIDTH'(item.write_data);
                REG_MASK:    mask_next    = item.write_data[1:0];
                REG_FLAGS:   flags_next   = flags_reg & ~item.write_data[1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (item.reg_select)
            REG_CONTROL: read_byte = {4'd0, ctrl_reg};
            REG_COUNTER: read_byte = count_reg[7:0];
            REG_COMPARE: read_byte = compare_reg[7:0];
            REG_MASK:    read_byte = {6'd0, mask_reg};
            REG_FLAGS:   read_byte = {6'd0, flags_reg};
            default:     read_byte = 8'd0;
        endcase
    end

    assign result.read_data     = is_read ? read_byte : 8'd0;
    assign result.overflow_flag = flags_next[FLAG_OVF];
    assign result.compare_flag  = flags_next[FLAG_CMP];
    assign result.irq           = |(flags_next & mask_next);

    assign status.flags   = flags_reg;
    assign status.enables = mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            compare_reg <= '0;
            ctrl_reg    <= '0;
            mask_reg    <= '0;
            flags_reg   <= '0;
        end
        else if (fire)
        begin
            count_reg   <= count_next;
            compare_reg <= compare_next;
            ctrl_reg    <= ctrl_next;
            mask_reg    <= mask_next;
            flags_reg   <= flags_next;
        end
    end

endmodule

/* rtl/core/timer_counter_prescaler_ctc_unit.sv */
// Top level: input stage, timer datapath and result register.
// Flow: an accepted beat is held in the input stage and is processed as it moves
// into the result register, which holds its result until it is taken.
// Throughput: one beat per cycle; the input stage and the result register
// both advance whenever the result register is empty or being taken.
// Reset: rst_n empties both stages and clears the prescaler, counter, compare,
// control, mask and flags at once; no clearing pass.
module timer_counter_prescaler_ctc_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  tmr_pkg::tmr_in_t  req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output tmr_pkg::tmr_out_t rsp
);
    import tmr_pkg::*;

    logic                stage_valid_reg;
    tmr_in_t             stage_reg;
    logic                rsp_valid_reg;
    tmr_out_t            rsp_reg;
    logic                advance;
    logic                fire;
    logic                count_event;
    tick_ctrl_t          tick_ctrl;
    tmr_out_t            result;
    tmr_status_t         status;

    assign advance   = !rsp_valid_reg || rsp_ready;
    assign fire      = stage_valid_reg && advance;
    assign req_ready = !stage_valid_reg || advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    tmr_prescaler u_prescaler (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (tick_ctrl),
        .count_event (count_event)
    );

    tmr_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .item        (stage_reg),
        .count_event (count_event),
        .tick_ctrl   (tick_ctrl),
        .result      (result),
        .status      (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (req_ready)
                stage_valid_reg <= req_valid;
            if (advance)
                rsp_valid_reg <= stage_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
            stage_reg <= req;
        if (fire)
            rsp_reg <= result;
    end

    a_rsp_tracks_flags: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.overflow_flag == status.flags[FLAG_OVF])
                   && (rsp.compare_flag == status.flags[FLAG_CMP])
                   && (rsp.irq == |(status.flags & status.enables)))
        else $error("result flags disagree with flag registers");

    a_fire_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> rsp_valid)
        else $error("processed beat produced no result");

    a_flag_clear: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (stage_reg.operation == OP_WRITE) && (stage_reg.reg_select == REG_FLAGS)
            && stage_reg.write_data[FLAG_OVF] |=> !status.flags[FLAG_OVF])
        else $error("overflow flag not cleared by write");

endmodule

/* dv/tmr_result_checker.sv */
`timescale 1ns / 100ps
// Checker for the timer/counter: predicts each result beat and compares it with the block's output.
module tmr_result_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_ready,
    input  tmr_pkg::tmr_in_t  req,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  tmr_pkg::tmr_out_t rsp,
    output int                fail_count,
    output int                pending,
    output int                overflow_hits,
    output int                compare_hits,
    output int                ctc_clears
);
    import tmr_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic [PRESCALE_WIDTH-1:0] presc_q;
    logic [COUNT_WIDTH-1:0]    count_q;
    logic [COUNT_WIDTH-1:0]    match_q;
    logic [3:0]                ctrl_q;
    logic [1:0]                enables_q;
    logic [1:0]                flags_q;
    logic                      pin_q;

    tmr_out_t expected_beats[$];
    tmr_out_t predicted;
    tmr_out_t oldest;
    int       mismatches;
    int       ovf_n;
    int       cmp_n;
    int       ctc_n;

    assign overflow_hits = ovf_n;
    assign compare_hits  = cmp_n;
    assign ctc_clears    = ctc_n;

    function automatic void step_timer(input tmr_in_t beat, output tmr_out_t res);
        logic [COUNT_WIDTH-1:0] prior;
        logic                   fire;
        res  = '0;
        fire = 1'b0;
        case (beat.operation)
            OP_TICK:
            begin
                presc_q = presc_q + PRESCALE_WIDTH'(1);
                case (ctrl_q[2:0])
                    CS_DIV1:    fire = 1'b1;
                    CS_DIV8:    fire = (presc_q[2:0] == '0);
                    CS_DIV64:   fire = (presc_q[5:0] == '0);
                    CS_DIV256:  fire = (presc_q[7:0] == '0);
                    CS_DIV1024: fire = (presc_q == '0);
                    CS_FALL:    fire = pin_q && !beat.ext_pin;
                    CS_RISE:    fire = !pin_q && beat.ext_pin;
                    default:    fire = 1'b0;
                endcase
                if (fire)
                begin
                    prior = count_q;
                    if (ctrl_q[3] && prior == match_q)
                    begin
                        count_q = '0;
                        ctc_n++;
                    end
                    else
                    begin
                        count_q = prior + COUNT_WIDTH'(1);
                    end
                    if (prior == '1 && count_q == '0)
                    begin
                        flags_q[FLAG_OVF] = 1'b1;
                        ovf_n++;
                    end
                    if (count_q == match_q)
                    begin
                        flags_q[FLAG_CMP] = 1'b1;
                        cmp_n++;
                    end
                end
                pin_q = beat.ext_pin;
            end
            OP_READ:
            begin
                case (beat.reg_select)
                    REG_CONTROL: res.read_data = {4'b0, ctrl_q};
                    REG_COUNTER: res.read_data = count_q[BYTE_WIDTH-1:0];
                    REG_COMPARE: res.read_data = match_q[BYTE_WIDTH-1:0];
                    REG_MASK:    res.read_data = {6'b0, enables_q};
                    REG_FLAGS:   res.read_data = {6'b0, flags_q};
                    default:     res.read_data = '0;
                endcase
            end
            OP_WRITE:
            begin
                case (beat.reg_select)
                    REG_CONTROL: ctrl_q    = beat.write_data[3:0];
                    REG_COUNTER: count_q   = COUNT_WIDTH'(beat.write_data);
                    REG_COMPARE: match_q   = COUNT_WIDTH'(beat.write_data);
                    REG_MASK:    enables_q = beat.write_data[1:0];
                    REG_FLAGS:   flags_q   = flags_q & ~beat.write_data[1:0];
                    default:     ;
                endcase
            end
            default: ;
        endcase
        res.overflow_flag = flags_q[FLAG_OVF];
        res.compare_flag  = flags_q[FLAG_CMP];
        res.irq           = |(flags_q & enables_q);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            presc_q   = '0;
            count_q   = '0;
            match_q   = '0;
            ctrl_q    = '0;
            enables_q = '0;
            flags_q   = '0;
            pin_q     = 1'b0;
            expected_beats.delete();
            pending    <= 0;
            fail_count <= mismatches;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                step_timer(req, predicted);
                expected_beats.push_back(predicted);
            end
            if (rsp_valid && rsp_ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result beat with nothing expected: rd=%h ovf=%b cmp=%b irq=%b",
                                 $realtime, rsp.read_data, rsp.overflow_flag, rsp.compare_flag,
                                 rsp.irq);
                end
                else
                begin
                    oldest = expected_beats.pop_front();
                    if (rsp.read_data !== oldest.read_data
                        || rsp.overflow_flag !== oldest.overflow_flag
                        || rsp.compare_flag !== oldest.compare_flag
                        || rsp.irq !== oldest.irq)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t: mismatch: rd %h/%h ovf %b/%b cmp %b/%b irq %b/%b (exp/got)",
                                     $realtime, oldest.read_data, rsp.read_data,
                                     oldest.overflow_flag, rsp.overflow_flag,
                                     oldest.compare_flag, rsp.compare_flag, oldest.irq, rsp.irq);
                    end
                end
            end
            pending    <= expected_beats.size();
            fail_count <= mismatches;
        end
    end

endmodule

/* dv/tb_timer_counter_prescaler_ctc_unit.sv */
`timescale 1ns / 100ps
// Testbench top for the timer/counter: reset, stimulus, flow control and verdict.
module tb_timer_counter_prescaler_ctc_unit;
    import tmr_pkg::*;

    localparam logic [1:0] OP_NONE       = 2'd3;
    localparam logic [2:0] REG_SPARE_LO  = 3'd5;
    localparam logic [2:0] REG_SPARE_HI  = 3'd7;
    localparam int         TOTAL_BEATS   = 1250;
    localparam int         LONG_HOLD_AT  = 700;
    localparam int         LONG_HOLD     = 90;
    localparam int         WATCHDOG_MAX  = 1000;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    tmr_in_t  req = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    tmr_out_t rsp;

    int fail_count;
    int pending;
    int overflow_hits;
    int compare_hits;
    int ctc_clears;

    int burst_left = 0;
    int beats_sent = 0;
    int rx_cycle = 0;
    int hold_left = 0;
    int phase_left = 0;
    int rx_style = 0;
    int idle_cycles = 0;

    logic [2:0] cs_menu [16] = '{CS_DIV1, CS_DIV1, CS_DIV1, CS_DIV1, CS_DIV1, CS_DIV8, CS_DIV8,
                                 CS_DIV64, CS_DIV256, CS_DIV1024, CS_FALL, CS_FALL, CS_RISE,
                                 CS_RISE, CS_STOP, CS_DIV1};

    always #2 clk = ~clk;

    timer_counter_prescaler_ctc_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    tmr_result_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req           (req),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .rsp           (rsp),
        .fail_count    (fail_count),
        .pending       (pending),
        .overflow_hits (overflow_hits),
        .compare_hits  (compare_hits),
        .ctc_clears    (ctc_clears)
    );

    task automatic send_beat(input logic [1:0] op, input logic [2:0] sel,
                             input logic [7:0] data, input logic pin);
        tmr_in_t beat;
        int      gap;
        beat.operation  = op;
        beat.reg_select = sel;
        beat.write_data = data;
        beat.ext_pin    = pin;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 40);
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        req_valid <= 1'b1;
        req       <= beat;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        burst_left--;
        beats_sent++;
    endtask

    task automatic tick(input logic pin);
        send_beat(OP_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), pin);
    endtask

    task automatic bus_write(input logic [2:0] sel, input logic [7:0] data);
        send_beat(OP_WRITE, sel, data, 1'($urandom_range(0, 1)));
    endtask

    task automatic bus_read(input logic [2:0] sel);
        send_beat(OP_READ, sel, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic drain_results;
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic run_count_sequence;
        logic [7:0] match;
        logic [7:0] start;
        logic [2:0] cs;
        logic       pin;
        int         n;
        int         pick;
        pick = $urandom_range(0, 7);
        if (pick < 2)
            match = 8'hFF;
        else if (pick == 2)
            match = 8'h00;
        else
            match = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0:       start = match - 8'($urandom_range(0, 6));
            1:       start = 8'hFF - 8'($urandom_range(0, 6));
            2:       start = match;
            default: start = 8'($urandom_range(0, 255));
        endcase
        cs = cs_menu[$urandom_range(0, 15)];
        bus_write(REG_COMPARE, match);
        bus_write(REG_COUNTER, start);
        bus_write(REG_MASK, 8'($urandom_range(0, 255)));
        bus_write(REG_CONTROL, {4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), cs});
        n = $urandom_range(8, 48);
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 15);
            pin  = 1'($urandom_range(0, 1));
            if (pick == 0)
                bus_read(3'($urandom_range(0, 4)));
            else if (pick == 1)
                bus_write(REG_FLAGS, 8'($urandom_range(0, 255)));
            else
                tick(pin);
        end
    endtask

    // receiver: styled stall phases plus occasional long hold-offs
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else
        begin
            rx_cycle <= rx_cycle + 1;
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                rsp_ready <= 1'b0;
            end
            else if (rx_cycle == LONG_HOLD_AT || $urandom_range(0, 4999) == 0)
            begin
                hold_left <= LONG_HOLD;
                rsp_ready <= 1'b0;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    rx_style   <= $urandom_range(0, 3);
                    phase_left <= $urandom_range(20, 200);
                end
                else
                begin
                    phase_left <= phase_left - 1;
                end
                case (rx_style)
                    0:       rsp_ready <= 1'b1;
                    1:       rsp_ready <= ($urandom_range(0, 3) != 0);
                    2:       rsp_ready <= rx_cycle[0];
                    default: rsp_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_MAX)
            begin
                $display("timer_counter_prescaler_ctc_unit regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int pick;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values, idle operation
        bus_read(REG_CONTROL);
        bus_read(REG_COUNTER);
        bus_read(REG_COMPARE);
        bus_read(REG_MASK);
        bus_read(REG_FLAGS);
        send_beat(OP_NONE, REG_COMPARE, 8'hFF, 1'b1);
        // wrap from maximum, then compare match
        bus_write(REG_COMPARE, 8'h03);
        bus_write(REG_MASK, 8'hFF);
        bus_write(REG_COUNTER, 8'hFE);
        bus_write(REG_CONTROL, {4'hF, 1'b0, CS_DIV1});
        repeat (5) tick(1'b0);
        bus_read(REG_FLAGS);
        bus_write(REG_FLAGS, 8'h01);
        bus_write(REG_FLAGS, 8'h02);
        // clear on compare, spare write ignored
        bus_write(REG_CONTROL, {4'h0, 1'b1, CS_DIV1});
        tick(1'b0);
        bus_write(REG_SPARE_HI, 8'hFF);
        bus_read(REG_SPARE_LO);
        // external pin edges
        bus_write(REG_CONTROL, {4'h0, 1'b0, CS_RISE});
        tick(1'b1);
        bus_write(REG_CONTROL, {4'h0, 1'b0, CS_FALL});
        tick(1'b0);
        drain_results();

        while (beats_sent < TOTAL_BEATS)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
            begin
                run_count_sequence();
            end
            else if (pick < 17)
            begin
                repeat ($urandom_range(3, 12))
                    send_beat(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            else if (pick < 19)
            begin
                for (int r = 0; r < 5; r++)
                    bus_read(3'(r));
                bus_write(REG_FLAGS, 8'($urandom_range(0, 255)));
            end
            else
            begin
                drain_results();
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        $display("covered %0d beats: %0d overflow wraps, %0d compare matches, %0d CTC clears",
                 beats_sent, overflow_hits, compare_hits, ctc_clears);
        if (fail_count == 0 && pending == 0)
            $display("timer_counter_prescaler_ctc_unit regression: pass");
        else
            $display("timer_counter_prescaler_ctc_unit regression: fail");
        $finish;
    end

endmodule
